### rtl/gso_pkg.sv
`default_nettype none

package gso_pkg;

	localparam int FRAME_W  = 24;
	localparam int STEP_W   = 24;
	localparam int DUR_W    = 24;
	localparam int CH_W     = 4;
	localparam int SAMPLE_W = 16;
	localparam int APB_AW   = 4;
	localparam int APB_DW   = 32;

	typedef enum logic [1:0] {
		REG_PHASE_STEP = 2'd0,
		REG_DURATION   = 2'd1,
		REG_CHANNELS   = 2'd2
	} reg_idx_t;

	localparam logic [CH_W-1:0] CH_RESET = CH_W'(2);

	typedef struct packed {
		logic [STEP_W-1:0] phase_step;
		logic [DUR_W-1:0]  duration;
		logic [CH_W-1:0]   channels;
	} cfg_t;

	// Quintic sine approximation, evaluated at elaboration only.
	function automatic logic [SAMPLE_W-1:0] sine_entry(input int unsigned tbits,
		input int unsigned k);
		logic [63:0] qsize, quad, r, u, u2, t1, t2, t3, t4, y, m;
		logic [63:0] neg;
		qsize = 64'd1 << (tbits - 2);
		quad  = (64'(k) >> (tbits - 2)) & 64'd3;
		r     = 64'(k) & (qsize - 64'd1);
		if (quad[0]) begin
			u = (qsize - r) << (18 - tbits);
		end else begin
			u = r << (18 - tbits);
		end
		u2 = (u * u) >> 16;
		t1 = (u2 * 64'd4640) >> 16;
		t2 = 64'd42047 - t1;
		t3 = (u2 * t2) >> 16;
		t4 = 64'd102944 - t3;
		y  = (u * t4) >> 16;
		m  = (y * 64'd32767 + 64'd32768) >> 16;
		if (m > 64'd32767) begin
			m = 64'd32767;
		end
		neg = 64'h10000 - m;
		if (quad[1]) begin
			return neg[SAMPLE_W-1:0];
		end
		return m[SAMPLE_W-1:0];
	endfunction

endpackage

`default_nettype wire

### rtl/gso_if.sv
`default_nettype none

interface gso_in_if import gso_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [FRAME_W-1:0] frame_index;

	modport source (output valid, output frame_index, input ready);
	modport sink   (input valid, input frame_index, output ready);
endinterface

interface gso_out_if import gso_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] sample;
	logic [CH_W-1:0]            channels_written;

	modport source (output valid, output sample, output channels_written, input ready);
	modport sink   (input valid, input sample, input channels_written, output ready);
endinterface

`default_nettype wire

### rtl/gso_regs.sv
`default_nettype none

module gso_regs import gso_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [APB_AW-1:0] paddr,
	input  wire logic [APB_DW-1:0] pwdata,
	output logic      [APB_DW-1:0] prdata,
	output logic                   pready,
	output cfg_t                   cfg
);

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr;

	assign idx    = reg_idx_t'(paddr[APB_AW-1:2]);
	assign wr     = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.phase_step <= '0;
			cfg_q.duration   <= '0;
			cfg_q.channels   <= CH_RESET;
		end else if (wr) begin
			case (idx)
				REG_PHASE_STEP: cfg_q.phase_step <= pwdata[STEP_W-1:0];
				REG_DURATION:   cfg_q.duration   <= pwdata[DUR_W-1:0];
				REG_CHANNELS:   cfg_q.channels   <= pwdata[CH_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_PHASE_STEP: prdata = APB_DW'(cfg_q.phase_step);
			REG_DURATION:   prdata = APB_DW'(cfg_q.duration);
			REG_CHANNELS:   prdata = APB_DW'(cfg_q.channels);
			default:        prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

### rtl/gso_phase.sv
`default_nettype none

module gso_phase import gso_pkg::*; #(
	parameter int PHASE_BITS   = 24,
	parameter int TABLE_BITS   = 10,
	parameter int MAX_CHANNELS = 8
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  load,
	input  wire logic [FRAME_W-1:0]    frame_index,
	input  wire cfg_t                  cfg,
	output logic                       active_s1,
	output logic      [TABLE_BITS-1:0] idx_s1,
	output logic      [CH_W-1:0]       ch_s1
);

	localparam int SUM_W    = (PHASE_BITS > STEP_W) ? PHASE_BITS : STEP_W;
	localparam int CH_FIELD = (1 << CH_W) - 1;
	localparam int CH_CAP   = (MAX_CHANNELS > CH_FIELD) ? CH_FIELD : MAX_CHANNELS;

	logic [PHASE_BITS-1:0] phase_q;
	logic [SUM_W-1:0]      sum;
	logic [PHASE_BITS-1:0] phase_nxt;
	logic [TABLE_BITS-1:0] idx_nxt;
	logic                  sounding;
	logic [CH_W-1:0]       ch_sat;

	assign sounding  = frame_index < cfg.duration;
	assign sum       = SUM_W'(phase_q) + SUM_W'(cfg.phase_step);
	assign phase_nxt = sum[PHASE_BITS-1:0];
	assign ch_sat    = (cfg.channels > CH_W'(CH_CAP)) ? CH_W'(CH_CAP) : cfg.channels;

	generate
		if (PHASE_BITS >= TABLE_BITS) begin : g_idx_top
			assign idx_nxt = phase_nxt[PHASE_BITS-1 -: TABLE_BITS];
		end else begin : g_idx_pad
			assign idx_nxt = {phase_nxt, {(TABLE_BITS - PHASE_BITS){1'b0}}};
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
		end else if (load && sounding) begin
			phase_q <= phase_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			active_s1 <= sounding;
			idx_s1    <= idx_nxt;
			ch_s1     <= sounding ? ch_sat : '0;
		end
	end

endmodule

`default_nettype wire

### rtl/gso_sine_rom.sv
`default_nettype none

module gso_sine_rom import gso_pkg::*; #(
	parameter int TABLE_BITS = 10
) (
	input  wire logic                  clk,
	input  wire logic                  en,
	input  wire logic [TABLE_BITS-1:0] addr,
	output logic      [SAMPLE_W-1:0]   data_q
);

	localparam int DEPTH = 1 << TABLE_BITS;

	logic [SAMPLE_W-1:0] rom [DEPTH];

	generate
		for (genvar k = 0; k < DEPTH; k++) begin : g_rom
			localparam logic [SAMPLE_W-1:0] ENTRY = sine_entry(TABLE_BITS, k);
			assign rom[k] = ENTRY;
		end
	endgenerate

	always_ff @(posedge clk) begin
		if (en) begin
			data_q <= rom[addr];
		end
	end

endmodule

`default_nettype wire

### rtl/gated_sine_oscillator_core.sv
// Channel     Dir  Handshake          Payload
// frame_ch    in   valid/ready        frame_index[23:0]
// sample_ch   out  valid/ready        sample[15:0] signed, channels_written[3:0]
// apb         in   psel/penable/pready paddr[3:0], pwdata/prdata[31:0]
//
// One frame accepted per cycle unless the output stalls; each result passes
// through the phase/gate register and then the registered sine ROM read.
// Reset clears phase accumulator, step, duration, pipeline valids; channels = 2.
// A stalled output holds both stages; stage 1 still fills while it is empty.
`default_nettype none

module gated_sine_oscillator_core import gso_pkg::*; #(
	parameter int PHASE_BITS   = 24,
	parameter int TABLE_BITS   = 10,
	parameter int MAX_CHANNELS = 8
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [APB_AW-1:0] paddr,
	input  wire logic [APB_DW-1:0] pwdata,
	output logic      [APB_DW-1:0] prdata,
	output logic                   pready,
	gso_in_if.sink                 frame_ch,
	gso_out_if.source              sample_ch
);

	cfg_t                  cfg;
	logic                  v_s1, v_s2;
	logic                  adv1, adv2, load;
	logic                  active_s1, active_s2;
	logic [TABLE_BITS-1:0] idx_s1;
	logic [CH_W-1:0]       ch_s1, ch_s2;
	logic [SAMPLE_W-1:0]   rom_data;

	gso_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	assign adv2 = !v_s2 || sample_ch.ready;
	assign adv1 = !v_s1 || adv2;
	assign load = frame_ch.valid && adv1;

	assign frame_ch.ready = adv1;

	gso_phase #(
		.PHASE_BITS   (PHASE_BITS),
		.TABLE_BITS   (TABLE_BITS),
		.MAX_CHANNELS (MAX_CHANNELS)
	) u_phase (
		.clk         (clk),
		.arst_n      (arst_n),
		.load        (load),
		.frame_index (frame_ch.frame_index),
		.cfg         (cfg),
		.active_s1   (active_s1),
		.idx_s1      (idx_s1),
		.ch_s1       (ch_s1)
	);

	gso_sine_rom #(
		.TABLE_BITS (TABLE_BITS)
	) u_rom (
		.clk    (clk),
		.en     (adv2),
		.addr   (idx_s1),
		.data_q (rom_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (adv1) begin
				v_s1 <= frame_ch.valid;
			end
			if (adv2) begin
				v_s2 <= v_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv2) begin
			active_s2 <= active_s1;
			ch_s2     <= ch_s1;
		end
	end

	assign sample_ch.valid            = v_s2;
	assign sample_ch.sample           = active_s2 ? $signed(rom_data) : '0;
	assign sample_ch.channels_written = ch_s2;

endmodule

`default_nettype wire
